[rtl/stereo_peak_rms_level_meter_core_assert.svh]
// assertion macros shared by the level meter rtl
`ifndef STEREO_PEAK_RMS_LEVEL_METER_CORE_ASSERT_SVH
`define STEREO_PEAK_RMS_LEVEL_METER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SPLM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define SPLM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

[rtl/splm_pkg.sv]
// types, constants and register codes of the stereo level meter
`default_nettype none

package splm_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int PEAK_W    = 15;
	localparam int SQ_W      = 30;
	localparam int MEAN_FRAC = 24;
	localparam int MEAN_W    = SQ_W + MEAN_FRAC;
	localparam int LO_W      = 32;
	localparam int CALC_W    = 64;
	localparam int ALPHA_W   = 24;
	localparam int DECAY_W   = 16;
	localparam int PERIOD_W  = 16;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;

	localparam int ALPHA_FRAC_BITS_DEF = 24;
	localparam int DECAY_FRAC_BITS_DEF = 16;

	localparam logic [PEAK_W-1:0]   PEAK_MAX = 15'h7fff;
	localparam logic [SQ_W-1:0]     SQ_MAX   = 30'd1073676289;
	localparam logic [MEAN_W-1:0]   MEAN_MAX = {SQ_MAX, {MEAN_FRAC{1'b0}}};

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd2400;
	localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 24'd1748;
	localparam logic [DECAY_W-1:0]  DECAY_RST  = 16'd58409;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIOD = 2'd0,
		CFG_ALPHA  = 2'd1,
		CFG_DECAY  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
	} in_t;

	typedef struct packed {
		logic [PEAK_W-1:0] peak_left;
		logic [PEAK_W-1:0] peak_right;
		logic [SQ_W-1:0]   mean_square_left;
		logic [SQ_W-1:0]   mean_square_right;
	} out_t;

	// step strobes from the sequencer, with the report flag from the merge, to both lanes
	typedef struct packed {
		logic take;
		logic diff;
		logic mul;
		logic upd;
		logic report;
	} lane_ctl_t;

	typedef struct packed {
		logic [PEAK_W-1:0] peak;
		logic [SQ_W-1:0]   mean_int;
	} lane_res_t;

	typedef struct packed {
		logic report;
		logic hold;
	} merge_stat_t;

endpackage

`default_nettype wire

[rtl/stereo_peak_rms_level_meter_core.sv]
// stereo peak and mean-square level meter, top level
// one pair is accepted at a time, in four steps: accept/square, difference, split multiply, mean update
// the two channel lanes run side by side through that shared four-step sequence
// a report is loaded into the output register in the mean update step of its pair
// the update step waits only while a report finds the output register still full
// arst_n clears peaks, means, pair count and sequencer and restores register defaults
`default_nettype none
`include "stereo_peak_rms_level_meter_core_assert.svh"

module stereo_peak_rms_level_meter_core #(
	parameter int ALPHA_FRAC_BITS = splm_pkg::ALPHA_FRAC_BITS_DEF,
	parameter int DECAY_FRAC_BITS = splm_pkg::DECAY_FRAC_BITS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  splm_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  wire                           out_ready,
	output splm_pkg::out_t                out_data,
	input  wire                           cfg_we,
	input  wire [splm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [splm_pkg::CFG_W-1:0]     cfg_wdata
);
	import splm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIFF = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_UPD  = 4'b1000
	} state_t;

	state_t              state_q;
	state_t              state_d;
	logic [PERIOD_W-1:0] period_q;
	logic [ALPHA_W-1:0]  alpha_q;
	logic [DECAY_W-1:0]  decay_q;
	logic                in_fire;
	lane_ctl_t           ctl;
	merge_stat_t         stat;
	lane_res_t           res_l;
	lane_res_t           res_r;

	assign in_ready = state_q == ST_IDLE;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		ctl.take   = in_fire;
		ctl.diff   = state_q == ST_DIFF;
		ctl.mul    = state_q == ST_MUL;
		ctl.upd    = (state_q == ST_UPD) && !stat.hold;
		ctl.report = stat.report;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: state_d = ST_MUL;
			ST_MUL:  state_d = ST_UPD;
			ST_UPD: begin
				if (!stat.hold) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			alpha_q  <= ALPHA_RST;
			decay_q  <= DECAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PERIOD: period_q <= cfg_wdata[PERIOD_W-1:0];
				CFG_ALPHA:  alpha_q  <= cfg_wdata[ALPHA_W-1:0];
				CFG_DECAY:  decay_q  <= cfg_wdata[DECAY_W-1:0];
				default: ;
			endcase
		end
	end

	splm_lane #(
		.ALPHA_FRAC_BITS(ALPHA_FRAC_BITS),
		.DECAY_FRAC_BITS(DECAY_FRAC_BITS)
	) u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (in_data.left_sample),
		.alpha  (alpha_q),
		.decay  (decay_q),
		.res    (res_l)
	);

	splm_lane #(
		.ALPHA_FRAC_BITS(ALPHA_FRAC_BITS),
		.DECAY_FRAC_BITS(DECAY_FRAC_BITS)
	) u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (in_data.right_sample),
		.alpha  (alpha_q),
		.decay  (decay_q),
		.res    (res_r)
	);

	splm_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (ctl.upd),
		.period    (period_q),
		.res_l     (res_l),
		.res_r     (res_r),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.stat      (stat)
	);

	`SPLM_ASSERT_NXT(a_busy_after_take, in_fire, !in_ready ##1 !in_ready ##1 !in_ready)
	`SPLM_ASSERT_IMP(a_result_from_update, $rose(out_valid), $past(ctl.upd) && $past(stat.report))

endmodule

`default_nettype wire

[rtl/splm_lane.sv]
// one channel: absolute value, held peak and smoothed square
`default_nettype none
`include "stereo_peak_rms_level_meter_core_assert.svh"

module splm_lane #(
	parameter int ALPHA_FRAC_BITS = splm_pkg::ALPHA_FRAC_BITS_DEF,
	parameter int DECAY_FRAC_BITS = splm_pkg::DECAY_FRAC_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  splm_pkg::lane_ctl_t                 ctl,
	input  wire signed [splm_pkg::SAMPLE_W-1:0] sample,
	input  wire [splm_pkg::ALPHA_W-1:0]         alpha,
	input  wire [splm_pkg::DECAY_W-1:0]         decay,
	output splm_pkg::lane_res_t                 res
);
	import splm_pkg::*;

	localparam int HI_W     = MEAN_W - LO_W;
	localparam int PL_W     = ALPHA_W + LO_W;
	localparam int PH_W     = ALPHA_W + HI_W;
	localparam int HI_SHIFT = LO_W - ALPHA_FRAC_BITS;
	localparam int DPROD_W  = PEAK_W + DECAY_W;

	logic [PEAK_W-1:0] peak_q;
	logic [MEAN_W-1:0] mean_q;
	logic [SQ_W-1:0]   sq_s1;
	logic [MEAN_W-1:0] mag_s2;
	logic              up_s2;
	logic [PL_W-1:0]   pl_s3;
	logic [PH_W-1:0]   ph_s3;
	logic              up_s3;

	logic [SAMPLE_W-1:0] raw;
	logic [SAMPLE_W-1:0] mag16;
	logic [PEAK_W-1:0]   abs_val;
	logic [MEAN_W-1:0]   sq_fix;
	logic                up_d;
	logic [CALC_W-1:0]   step;
	logic [CALC_W-1:0]   sum_up;
	logic [MEAN_W-1:0]   mean_up;
	logic [MEAN_W-1:0]   mean_dn;
	logic [MEAN_W-1:0]   mean_nxt;
	logic [DPROD_W-1:0]  dprod;
	logic [DPROD_W-1:0]  dshift;
	logic [PEAK_W-1:0]   peak_dec;

	// full scale negative saturates to the positive maximum
	always_comb begin
		raw     = sample;
		mag16   = raw[SAMPLE_W-1] ? (~raw + 16'd1) : raw;
		abs_val = mag16[SAMPLE_W-1] ? PEAK_MAX : mag16[PEAK_W-1:0];
	end

	always_comb begin
		sq_fix = {sq_s1, {MEAN_FRAC{1'b0}}};
		up_d   = sq_fix >= mean_q;
	end

	// split product recombined, then clamp to the valid mean range
	always_comb begin
		step     = (CALC_W'(ph_s3) << HI_SHIFT) + (CALC_W'(pl_s3) >> ALPHA_FRAC_BITS);
		sum_up   = CALC_W'(mean_q) + step;
		mean_up  = (sum_up > CALC_W'(MEAN_MAX)) ? MEAN_MAX : sum_up[MEAN_W-1:0];
		mean_dn  = (step >= CALC_W'(mean_q)) ? '0 : (mean_q - step[MEAN_W-1:0]);
		mean_nxt = up_s3 ? mean_up : mean_dn;
	end

	always_comb begin
		dprod    = DPROD_W'(peak_q) * DPROD_W'(decay);
		dshift   = dprod >> DECAY_FRAC_BITS;
		peak_dec = (dshift > DPROD_W'(PEAK_MAX)) ? PEAK_MAX : dshift[PEAK_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			mean_q <= '0;
		end else begin
			if (ctl.take && (abs_val > peak_q)) begin
				peak_q <= abs_val;
			end else if (ctl.upd && ctl.report) begin
				peak_q <= peak_dec;
			end
			if (ctl.upd) begin
				mean_q <= mean_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			sq_s1 <= SQ_W'(abs_val) * SQ_W'(abs_val);
		end
		if (ctl.diff) begin
			up_s2  <= up_d;
			mag_s2 <= up_d ? (sq_fix - mean_q) : (mean_q - sq_fix);
		end
		if (ctl.mul) begin
			up_s3 <= up_s2;
			pl_s3 <= PL_W'(alpha) * PL_W'(mag_s2[LO_W-1:0]);
			ph_s3 <= PH_W'(alpha) * PH_W'(mag_s2[MEAN_W-1:LO_W]);
		end
	end

	assign res.peak     = peak_q;
	assign res.mean_int = mean_nxt[MEAN_W-1:MEAN_FRAC];

	`SPLM_ASSERT_NXT(a_peak_grows_on_take, ctl.take, peak_q >= $past(peak_q))
	`SPLM_ASSERT_IMP(a_mean_in_range, 1'b1, mean_q <= MEAN_MAX)
	`SPLM_ASSERT_NXT(a_mean_only_on_upd, !ctl.upd, $stable(mean_q))

endmodule

`default_nettype wire

[rtl/splm_merge.sv]
// pair counter, report decision and result register
`default_nettype none
`include "stereo_peak_rms_level_meter_core_assert.svh"

module splm_merge (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          upd,
	input  wire [splm_pkg::PERIOD_W-1:0] period,
	input  splm_pkg::lane_res_t          res_l,
	input  splm_pkg::lane_res_t          res_r,
	output logic                         out_valid,
	input  wire                          out_ready,
	output splm_pkg::out_t               out_data,
	output splm_pkg::merge_stat_t        stat
);
	import splm_pkg::*;

	logic [PERIOD_W-1:0] count_q;
	logic                out_valid_q;
	out_t                out_q;
	logic                load;

	// greater-or-equal so a lowered period fires on the next pair
	assign stat.report = count_q >= period;
	assign stat.hold   = stat.report && out_valid_q && !out_ready;
	assign load        = upd && stat.report;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd) begin
				count_q <= stat.report ? '0 : (count_q + 16'd1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.peak_left         <= res_l.peak;
			out_q.peak_right        <= res_r.peak;
			out_q.mean_square_left  <= res_l.mean_int;
			out_q.mean_square_right <= res_r.mean_int;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SPLM_ASSERT_NXT(a_count_clears_on_report, load, count_q == '0 && out_valid_q)
	`SPLM_ASSERT_IMP(a_no_overwrite, load, !out_valid_q || out_ready)

endmodule

`default_nettype wire

[dv/stereo_peak_rms_level_meter_core_tb.sv]
`timescale 1ns / 1ps
// testbench of the stereo level meter core: predicted peak and mean-square reports versus the rtl
module stereo_peak_rms_level_meter_core_tb;
	import splm_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int SETTLE      = 12;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASES      = 12;
	localparam int PHASE_PAIRS = 125;
	localparam int IDLE_PCT    = 68;
	localparam int BOTH_PCT    = 32;
	localparam int ALPHA_FRAC  = ALPHA_FRAC_BITS_DEF;
	localparam int DECAY_FRAC  = DECAY_FRAC_BITS_DEF;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	class level_scoreboard;
		logic [PERIOD_W-1:0] period;
		logic [ALPHA_W-1:0]  alpha;
		logic [DECAY_W-1:0]  decay;
		logic [PEAK_W-1:0]   peak_l, peak_r;
		logic [MEAN_W-1:0]   msq_l, msq_r;
		logic [PERIOD_W-1:0] count;
		out_t                reports[$];
		int                  errors, pairs, reports_seen;

		function new();
			period = PERIOD_RST;
			alpha  = ALPHA_RST;
			decay  = DECAY_RST;
			peak_l = '0;
			peak_r = '0;
			msq_l  = '0;
			msq_r  = '0;
			count  = '0;
			errors = 0;
			pairs  = 0;
			reports_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_PERIOD: period = val[PERIOD_W-1:0];
				CFG_ALPHA: alpha = val[ALPHA_W-1:0];
				CFG_DECAY: decay = val[DECAY_W-1:0];
				default: ;
			endcase
		endfunction

		// full scale negative saturates to the largest positive magnitude
		function logic [PEAK_W-1:0] magnitude(logic signed [SAMPLE_W-1:0] s);
			logic [SAMPLE_W-1:0] a;
			a = s[SAMPLE_W-1] ? (16'd0 - s) : s;
			return (a > 16'(PEAK_MAX)) ? PEAK_MAX : a[PEAK_W-1:0];
		endfunction

		// step toward the new square by alpha times the distance, truncated toward zero
		function logic [MEAN_W-1:0] mean_step(logic [MEAN_W-1:0] m, logic [PEAK_W-1:0] a);
			logic [63:0] target, cur, q, r;
			logic [87:0] prod;
			cur = 64'(m);
			target = (64'(a) * 64'(a)) << MEAN_FRAC;
			if (target >= cur) begin
				prod = 88'(target - cur) * 88'(alpha);
				q = 64'(prod >> ALPHA_FRAC);
				r = cur + q;
				if (r > 64'(MEAN_MAX))
					r = 64'(MEAN_MAX);
			end else begin
				prod = 88'(cur - target) * 88'(alpha);
				q = 64'(prod >> ALPHA_FRAC);
				r = (q >= cur) ? 64'd0 : cur - q;
			end
			return r[MEAN_W-1:0];
		endfunction

		function logic [PEAK_W-1:0] decay_peak(logic [PEAK_W-1:0] p);
			logic [31:0] r;
			r = (32'(p) * 32'(decay)) >> DECAY_FRAC;
			return (r > 32'(PEAK_MAX)) ? PEAK_MAX : r[PEAK_W-1:0];
		endfunction

		function void note_pair(in_t d);
			out_t rep;
			logic [PEAK_W-1:0] al, ar;
			al = magnitude(d.left_sample);
			ar = magnitude(d.right_sample);
			if (al > peak_l)
				peak_l = al;
			if (ar > peak_r)
				peak_r = ar;
			msq_l = mean_step(msq_l, al);
			msq_r = mean_step(msq_r, ar);
			pairs++;
			if (count < period) begin
				count = count + 1'b1;
			end else begin
				rep.peak_left = peak_l;
				rep.peak_right = peak_r;
				rep.mean_square_left = msq_l[MEAN_W-1:MEAN_FRAC];
				rep.mean_square_right = msq_r[MEAN_W-1:MEAN_FRAC];
				reports.push_back(rep);
				count = '0;
				peak_l = decay_peak(peak_l);
				peak_r = decay_peak(peak_r);
			end
		endfunction

		function void compare_field(string name, logic [SQ_W-1:0] want, logic [SQ_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_report(out_t got);
			out_t want;
			if (reports.size() == 0) begin
				$error("report beat with none pending: %p", got);
				errors++;
				return;
			end
			want = reports.pop_front();
			reports_seen++;
			compare_field("peak_left", SQ_W'(want.peak_left), SQ_W'(got.peak_left));
			compare_field("peak_right", SQ_W'(want.peak_right), SQ_W'(got.peak_right));
			compare_field("mean_square_left", want.mean_square_left, got.mean_square_left);
			compare_field("mean_square_right", want.mean_square_right, got.mean_square_right);
		endfunction

		function int pending();
			return reports.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	level_scoreboard meter;
	bit tx_idle, rx_stall;
	int idle_pct = IDLE_PCT;
	int quiet = 0;
	int settings_seen = 0;

	stereo_peak_rms_level_meter_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(negedge clk) begin
		out_ready <= rx_stall ? ($urandom_range(99) >= idle_pct) : 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			meter.check_report(out_data);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// valid stays up across back-to-back beats, so it is only lowered for a gap
	task automatic send_pair(input logic signed [SAMPLE_W-1:0] l, input logic signed [SAMPLE_W-1:0] r);
		@(negedge clk);
		while (tx_idle && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{left_sample: l, right_sample: r};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		meter.note_pair(in_data);
	endtask

	task automatic release_input();
		@(negedge clk) in_valid <= 1'b0;
	endtask

	task automatic drain();
		release_input();
		while (meter.pending() != 0)
			@(posedge clk);
	endtask

	// pairs that make no report may still be in flight after the last report beat
	task automatic wait_idle();
		drain();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		meter.write_reg(idx, val);
	endtask

	task automatic cfg_done();
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	// upper bits of the 16-bit registers carry junk that must be dropped
	task automatic program_meter(input logic [PERIOD_W-1:0] period, input logic [ALPHA_W-1:0] alpha,
			input logic [DECAY_W-1:0] decay);
		cfg_write(CFG_PERIOD, {8'($urandom), period});
		cfg_write(CFG_ALPHA, alpha);
		cfg_write(CFG_DECAY, {8'($urandom), decay});
		cfg_done();
		settings_seen++;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return -16'sd1;
			4, 5: return 16'($signed($urandom_range(0, 511)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [PERIOD_W-1:0] period;
		logic [ALPHA_W-1:0]  alpha;
		logic [DECAY_W-1:0]  decay;
		meter = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_PERIOD;
		cfg_wdata = '0;
		tx_idle = 1'b0;
		rx_stall = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// report on every pair, smoothing and decay left at their reset values
		cfg_write(CFG_PERIOD, {8'ha5, 16'd0});
		cfg_done();
		send_pair(16'sh0000, 16'sh0000);
		send_pair(16'sh7fff, 16'sh8000);
		send_pair(16'sh8000, 16'sh7fff);
		send_pair(-16'sd1, 16'sd1);
		send_pair(16'sd1, -16'sd32767);
		send_pair(16'sh5555, 16'shaaaa);
		send_pair(16'sh8000, 16'sh8000);

		wait_idle();
		program_meter(16'd0, 24'hffffff, 16'hffff);
		send_pair(16'sh7fff, 16'sh7fff);
		send_pair(16'sh0000, 16'sh0000);
		send_pair(16'sh8000, 16'sd1);
		send_pair(16'sd100, -16'sd100);

		wait_idle();
		program_meter(16'd0, 24'd0, 16'd0);
		send_pair(16'sd12345, -16'sd12345);
		send_pair(16'sh7fff, 16'sh0000);

		// count builds under the largest period, then the period drops below it
		wait_idle();
		program_meter(16'hffff, 24'h800000, 16'h8000);
		repeat (6) send_pair(pick_sample(), pick_sample());
		wait_idle();
		cfg_write(CFG_PERIOD, 24'd4);
		cfg_done();
		send_pair(pick_sample(), pick_sample());
		wait_idle();
		cfg_write(CFG_UNUSED, 24'($urandom));
		cfg_done();
		repeat (5) send_pair(pick_sample(), pick_sample());

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			case (ph % 4)
				0: period = 16'd0;
				1: period = 16'($urandom_range(1, 3));
				2: period = 16'($urandom_range(4, 20));
				default: period = 16'($urandom_range(0, 60));
			endcase
			case (ph % 5)
				0: alpha = 24'hffffff;
				1: alpha = 24'd0;
				2: alpha = 24'($urandom_range(1, 4096));
				3: alpha = 24'($urandom);
				default: alpha = ALPHA_RST;
			endcase
			case (ph % 3)
				0: decay = 16'hffff;
				1: decay = 16'd0;
				default: decay = 16'($urandom);
			endcase
			program_meter(period, alpha, decay);
			idle_pct = (ph[0] && ph[1]) ? BOTH_PCT : IDLE_PCT;
			tx_idle = ph[0];
			rx_stall = ph[1];
			for (int k = 0; k < PHASE_PAIRS; k++) begin
				if (k == PHASE_PAIRS / 2 || $urandom_range(49) == 0)
					drain();
				send_pair(pick_sample(), pick_sample());
			end
		end

		wait_idle();
		$display("level meter run: %0d sample pairs in, %0d reports checked", meter.pairs,
			meter.reports_seen);
		$display("register settings applied: %0d, with and without idle and stall on each side",
			settings_seen);
		if (meter.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/splm_pkg.sv
rtl/splm_lane.sv
rtl/splm_merge.sv
rtl/stereo_peak_rms_level_meter_core.sv
dv/stereo_peak_rms_level_meter_core_tb.sv
